@@ hdl/trc_pkg.sv @@
// shared types, constants and the arctangent table for the remap coordinate generator
package trc_pkg;

  // field widths
  localparam int POS_W    = 14;
  localparam int ORG_W    = 15;
  localparam int FOCAL_W  = 21;
  localparam int OUT_W    = 19;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;

  // datapath widths
  localparam int MAG_W    = 15;
  localparam int CRD_W    = 33;
  localparam int REM_W    = 31;
  localparam int QUO_W    = 31;

  // pipeline lengths
  localparam int DIV1_STEPS   = 31;
  localparam int CORDIC_STEPS = 30;
  localparam int DIV2_STEPS   = 23;
  localparam int PIPE_DEPTH   = DIV1_STEPS + CORDIC_STEPS + DIV2_STEPS + 5;

  localparam logic [FOCAL_W-1:0] FOCAL_MIN   = 21'd256;
  localparam logic [FOCAL_W-1:0] FOCAL_RESET = 21'd256000;
  localparam logic [QUO_W-1:0]   HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 19'sh3FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 19'sh40000;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_FOCAL    = 3'd0,
    REG_CENTER_X = 3'd1,
    REG_CENTER_Y = 3'd2,
    REG_ORIGIN_L = 3'd3,
    REG_ORIGIN_T = 3'd4
  } cfg_reg_t;

  // per-item flags that travel along the chain
  typedef struct packed {
    logic nneg;
    logic sat;
    logic neg;
  } side_t;

  // atan(2^-i) in Q2.30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/trc_ifs.sv @@
// valid/ready channel interfaces for pixel positions and source coordinates
interface trc_in_if import trc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] out_col;
  logic [POS_W-1:0] out_row;

  modport source (output valid, output out_col, output out_row, input ready);
  modport sink   (input valid, input out_col, input out_row, output ready);
endinterface

interface trc_out_if import trc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] src_x_q5;
  logic signed [OUT_W-1:0] src_y_q5;

  modport source (output valid, output src_x_q5, output src_y_q5, input ready);
  modport sink   (input valid, input src_x_q5, input src_y_q5, output ready);
endinterface

@@ hdl/trc_div_cell.sv @@
// one restoring division step: brings down a dividend bit, subtracts when it fits
module trc_div_cell import trc_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [REM_W-1:0] rem_i,
  input  logic [REM_W-1:0] low_i,
  input  logic [QUO_W-1:0] quo_i,
  input  logic [REM_W-1:0] dvs_i,
  input  side_t            side_i,
  output logic [REM_W-1:0] rem_o,
  output logic [REM_W-1:0] low_o,
  output logic [QUO_W-1:0] quo_o,
  output logic [REM_W-1:0] dvs_o,
  output side_t            side_o
);

  logic [REM_W:0]   trial;
  logic             fits;
  logic [REM_W-1:0] rem_nxt;

  // shift in next dividend bit and compare against divisor
  assign trial   = {rem_i, low_i[REM_W-1]};
  assign fits    = trial >= {1'b0, dvs_i};
  assign rem_nxt = fits ? REM_W'(trial - {1'b0, dvs_i}) : REM_W'(trial);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= rem_nxt;
      low_o  <= {low_i[REM_W-2:0], 1'b0};
      quo_o  <= {quo_i[QUO_W-2:0], fits};
      dvs_o  <= dvs_i;
      side_o <= side_i;
    end
  end

endmodule

@@ hdl/trc_cordic_cell.sv @@
// one cordic rotation step; the step index is tied to a constant per cell
module trc_cordic_cell import trc_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [4:0]              step_i,
  input  logic signed [CRD_W-1:0] x_i,
  input  logic signed [CRD_W-1:0] y_i,
  input  logic signed [CRD_W-1:0] z_i,
  input  side_t                   side_i,
  output logic signed [CRD_W-1:0] x_o,
  output logic signed [CRD_W-1:0] y_o,
  output logic signed [CRD_W-1:0] z_o,
  output side_t                   side_o
);

  logic signed [CRD_W-1:0] dx;
  logic signed [CRD_W-1:0] dy;
  logic signed [CRD_W-1:0] ang;

  assign dx  = y_i >>> step_i;
  assign dy  = x_i >>> step_i;
  assign ang = $signed({3'b000, atan_q30(step_i)});

  // rotate toward zero residual angle
  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_i[CRD_W-1]) begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        z_o <= z_i - ang;
      end else begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        z_o <= z_i + ang;
      end
      side_o <= side_i;
    end
  end

endmodule

@@ hdl/trc_axis.sv @@
// one axis: angle divide, cordic tangent, scale divide, round and clamp
module trc_axis import trc_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic [POS_W-1:0]          pos,
  input  logic signed [ORG_W-1:0]   origin,
  input  logic [FOCAL_W-1:0]        focal,
  input  logic [FOCAL_W-1:0]        center,
  output logic signed [OUT_W-1:0]   coord
);

  // position plus origin, magnitude and sign
  logic signed [16:0] n_s;
  logic [MAG_W-1:0]   mag_r;
  logic               nneg_r;

  assign n_s = $signed({3'b000, pos}) + 17'(origin);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= n_s[16] ? MAG_W'(-n_s) : n_s[MAG_W-1:0];
      nneg_r <= n_s[16];
    end
  end

  // angle dividend with rounding term, overflow when quotient needs 32 bits
  logic [53:0] num1;
  logic        ovf1;

  assign num1 = {1'b0, mag_r, 38'd0} + 54'(focal[FOCAL_W-1:1]);
  assign ovf1 = num1 >= 54'({focal, 31'd0});

  logic [REM_W-1:0] d1_rem [DIV1_STEPS+1];
  logic [REM_W-1:0] d1_low [DIV1_STEPS+1];
  logic [QUO_W-1:0] d1_quo [DIV1_STEPS+1];
  logic [REM_W-1:0] d1_dvs [DIV1_STEPS+1];
  side_t            d1_side[DIV1_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      d1_rem[0]  <= REM_W'(num1[53:31]);
      d1_low[0]  <= num1[30:0];
      d1_quo[0]  <= '0;
      d1_dvs[0]  <= REM_W'(focal);
      d1_side[0] <= '{nneg: nneg_r, sat: ovf1, neg: nneg_r};
    end
  end

  for (genvar k = 0; k < DIV1_STEPS; k++) begin : g_div1
    trc_div_cell u_cell (
      .clk(clk), .en(en),
      .rem_i(d1_rem[k]), .low_i(d1_low[k]), .quo_i(d1_quo[k]),
      .dvs_i(d1_dvs[k]), .side_i(d1_side[k]),
      .rem_o(d1_rem[k+1]), .low_o(d1_low[k+1]), .quo_o(d1_quo[k+1]),
      .dvs_o(d1_dvs[k+1]), .side_o(d1_side[k+1])
    );
  end

  // cordic seed; right angle or beyond saturates
  logic signed [CRD_W-1:0] cx [CORDIC_STEPS+1];
  logic signed [CRD_W-1:0] cy [CORDIC_STEPS+1];
  logic signed [CRD_W-1:0] cz [CORDIC_STEPS+1];
  side_t                   cs [CORDIC_STEPS+1];
  side_t                   s1;

  always_comb begin
    s1     = d1_side[DIV1_STEPS];
    s1.sat = s1.sat || (d1_quo[DIV1_STEPS] >= HALF_PI_Q30);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= CRD_W'(34'sd1073741824);
      cy[0] <= '0;
      cz[0] <= $signed({2'b00, d1_quo[DIV1_STEPS]});
      cs[0] <= s1;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    trc_cordic_cell u_cell (
      .clk(clk), .en(en), .step_i(5'(k)),
      .x_i(cx[k]), .y_i(cy[k]), .z_i(cz[k]), .side_i(cs[k]),
      .x_o(cx[k+1]), .y_o(cy[k+1]), .z_o(cz[k+1]), .side_o(cs[k+1])
    );
  end

  // sign, vanishing cosine and |y| * focal
  logic signed [CRD_W-1:0] xf;
  logic signed [CRD_W-1:0] yf;
  logic [30:0]             ay;
  side_t                   s2;
  logic [51:0]             prod_r;
  logic [REM_W-1:0]        xd_r;
  side_t                   sd_r;

  assign xf = cx[CORDIC_STEPS];
  assign yf = cy[CORDIC_STEPS];
  assign ay = yf[CRD_W-1] ? 31'(-yf) : yf[30:0];

  always_comb begin
    s2 = cs[CORDIC_STEPS];
    if (!s2.sat) begin
      s2.neg = s2.nneg ^ yf[CRD_W-1];
      s2.sat = xf[CRD_W-1] || (xf == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= ay * focal;
      xd_r   <= xf[REM_W-1:0];
      sd_r   <= s2;
    end
  end

  // scale dividend with rounding term; quotients of 2^23 and above saturate
  logic [52:0] num2;
  logic        ovf2;
  side_t       s3;

  assign num2 = 53'(prod_r) + 53'(xd_r[REM_W-1:1]);
  assign ovf2 = 54'(num2) >= 54'({xd_r, 23'd0});

  always_comb begin
    s3     = sd_r;
    s3.sat = sd_r.sat || ovf2;
  end

  logic [REM_W-1:0] d2_rem [DIV2_STEPS+1];
  logic [REM_W-1:0] d2_low [DIV2_STEPS+1];
  logic [QUO_W-1:0] d2_quo [DIV2_STEPS+1];
  logic [REM_W-1:0] d2_dvs [DIV2_STEPS+1];
  side_t            d2_side[DIV2_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      d2_rem[0]  <= REM_W'(num2[52:23]);
      d2_low[0]  <= {num2[22:0], 8'd0};
      d2_quo[0]  <= '0;
      d2_dvs[0]  <= xd_r;
      d2_side[0] <= s3;
    end
  end

  for (genvar k = 0; k < DIV2_STEPS; k++) begin : g_div2
    trc_div_cell u_cell (
      .clk(clk), .en(en),
      .rem_i(d2_rem[k]), .low_i(d2_low[k]), .quo_i(d2_quo[k]),
      .dvs_i(d2_dvs[k]), .side_i(d2_side[k]),
      .rem_o(d2_rem[k+1]), .low_o(d2_low[k+1]), .quo_o(d2_quo[k+1]),
      .dvs_o(d2_dvs[k+1]), .side_o(d2_side[k+1])
    );
  end

  // add center, round to q5, clamp
  logic [22:0]        v8;
  logic signed [25:0] sv;
  logic signed [22:0] sh;
  side_t              sf;

  assign sf = d2_side[DIV2_STEPS];
  assign v8 = d2_quo[DIV2_STEPS][22:0];
  assign sv = (sf.neg ? -$signed({3'b000, v8}) : $signed({3'b000, v8}))
              + $signed({5'b00000, center}) + 26'sd4;
  assign sh = 23'(sv >>> 3);

  always_comb begin
    if (sf.sat) begin
      coord = sf.neg ? OUT_MIN : OUT_MAX;
    end else if (sh > 23'(OUT_MAX)) begin
      coord = OUT_MAX;
    end else if (sh < 23'(OUT_MIN)) begin
      coord = OUT_MIN;
    end else begin
      coord = sh[OUT_W-1:0];
    end
  end

endmodule

@@ hdl/tangential_remap_coordinate_generator.sv @@
// top level: register port, two axis chains, valid tracking and output skid stage
// throughput: one item per cycle while the skid entry is empty, set by the fully pipelined divider and cordic cell rows
// a stalled output holds one result and parks one more before input stalls
// reset: synchronous active-low; clears valids, focal length to 256000, other config registers to 0
// no clearing pass; items are accepted from the first cycle after reset
module tangential_remap_coordinate_generator import trc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  trc_in_if.sink            in_ch,
  trc_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  // configuration registers
  logic [FOCAL_W-1:0]      focal_r;
  logic [FOCAL_W-1:0]      center_x_r;
  logic [FOCAL_W-1:0]      center_y_r;
  logic signed [ORG_W-1:0] origin_l_r;
  logic signed [ORG_W-1:0] origin_t_r;
  cfg_reg_t                reg_idx;
  logic                    wr_en;

  assign reg_idx = cfg_reg_t'(paddr[CFG_AW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r    <= FOCAL_RESET;
      center_x_r <= '0;
      center_y_r <= '0;
      origin_l_r <= '0;
      origin_t_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FOCAL:    focal_r    <= pwdata[FOCAL_W-1:0];
        REG_CENTER_X: center_x_r <= pwdata[FOCAL_W-1:0];
        REG_CENTER_Y: center_y_r <= pwdata[FOCAL_W-1:0];
        REG_ORIGIN_L: origin_l_r <= pwdata[ORG_W-1:0];
        REG_ORIGIN_T: origin_t_r <= pwdata[ORG_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_FOCAL:    prdata = CFG_DW'(focal_r);
      REG_CENTER_X: prdata = CFG_DW'(center_x_r);
      REG_CENTER_Y: prdata = CFG_DW'(center_y_r);
      REG_ORIGIN_L: prdata = CFG_DW'($unsigned(origin_l_r));
      REG_ORIGIN_T: prdata = CFG_DW'($unsigned(origin_t_r));
      default:      prdata = '0;
    endcase
  end

  // small focal lengths are raised to one pixel
  logic [FOCAL_W-1:0] focal_eff;
  assign focal_eff = (focal_r < FOCAL_MIN) ? FOCAL_MIN : focal_r;

  // pipeline advance and item valid chain
  logic                  en;
  logic                  skid_vld_r;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  accept;

  assign en          = !skid_vld_r;
  assign in_ch.ready = en;
  assign accept      = in_ch.valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], accept};
    end
  end

  logic signed [OUT_W-1:0] x_res;
  logic signed [OUT_W-1:0] y_res;

  trc_axis u_axis_x (
    .clk(clk), .en(en), .pos(in_ch.out_col), .origin(origin_l_r),
    .focal(focal_eff), .center(center_x_r), .coord(x_res)
  );

  trc_axis u_axis_y (
    .clk(clk), .en(en), .pos(in_ch.out_row), .origin(origin_t_r),
    .focal(focal_eff), .center(center_y_r), .coord(y_res)
  );

  // output register with one skid entry
  logic                    out_vld_r;
  logic signed [OUT_W-1:0] out_x_r;
  logic signed [OUT_W-1:0] out_y_r;
  logic signed [OUT_W-1:0] skid_x_r;
  logic signed [OUT_W-1:0] skid_y_r;
  logic                    take;
  logic                    arrive;

  assign take   = out_vld_r && out_ch.ready;
  assign arrive = en && vld_r[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (take) begin
        out_x_r    <= skid_x_r;
        out_y_r    <= skid_y_r;
        skid_vld_r <= 1'b0;
      end
    end else if (arrive) begin
      if (!out_vld_r || take) begin
        out_x_r   <= x_res;
        out_y_r   <= y_res;
        out_vld_r <= 1'b1;
      end else begin
        skid_x_r   <= x_res;
        skid_y_r   <= y_res;
        skid_vld_r <= 1'b1;
      end
    end else if (take) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.src_x_q5 = out_x_r;
  assign out_ch.src_y_q5 = out_y_r;

endmodule

@@ tb/tb.sv @@
// testbench for the tangential remap coordinate generator
`timescale 1ns / 1ps

module tb;
  import trc_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 120;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int NUM_PHASES = 8;

  typedef struct {
    logic signed [OUT_W-1:0] src_x;
    logic signed [OUT_W-1:0] src_y;
  } coord_t;

  typedef struct {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    bit known;
    logic signed [OUT_W-1:0] ex;
    logic signed [OUT_W-1:0] ey;
  } pixel_row_t;

  // atan(2^-i) in Q2.30
  localparam longint ARCTAN_Q30 [CORDIC_STEPS] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149,
    1048576, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64,
    32, 16, 8, 4, 2
  };

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  trc_in_if in_ch ();
  trc_out_if out_ch ();

  tangential_remap_coordinate_generator u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the register file
  logic [FOCAL_W-1:0] focal_sh;
  logic [FOCAL_W-1:0] cx_sh;
  logic [FOCAL_W-1:0] cy_sh;
  logic signed [ORG_W-1:0] ol_sh;
  logic signed [ORG_W-1:0] ot_sh;

  coord_t coord_q[$];
  int mismatches = 0;
  int failures = 0;
  int idle_cycles = 0;
  int burst_left;
  int stall_mode = 0;
  int stall_timer = 0;

  // clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // tangent projection of one axis onto the source plane
  function automatic logic signed [OUT_W-1:0] tan_project(int n, logic [FOCAL_W-1:0] focal,
                                                          logic [FOCAL_W-1:0] center);
    longint f, mag, ang, x, y, z, dx, dy, ay, v8, r;
    bit nneg, neg;
    f = (focal < FOCAL_MIN) ? longint'(FOCAL_MIN) : longint'(focal);
    nneg = n < 0;
    mag = nneg ? -longint'(n) : longint'(n);
    ang = ((mag << 38) + (f >> 1)) / f;
    if (ang >= 64'sd1686629713) return nneg ? OUT_MIN : OUT_MAX;
    x = longint'(1) << 30;
    y = 0;
    z = ang;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ARCTAN_Q30[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ARCTAN_Q30[i];
      end
    end
    neg = nneg != (y < 0);
    if (x <= 0) return neg ? OUT_MIN : OUT_MAX;
    ay = (y < 0) ? -y : y;
    v8 = (ay * f + (x >> 1)) / x;
    if (neg) v8 = -v8;
    r = (v8 + longint'(center) + 4) >>> 3;
    if (r > 262143) r = 262143;
    if (r < -262144) r = -262144;
    return r[OUT_W-1:0];
  endfunction

  // register write over the config port, shadow follows
  task automatic reg_write(cfg_reg_t idx, logic [CFG_DW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FOCAL:    focal_sh = val[FOCAL_W-1:0];
      REG_CENTER_X: cx_sh = val[FOCAL_W-1:0];
      REG_CENTER_Y: cy_sh = val[FOCAL_W-1:0];
      REG_ORIGIN_L: ol_sh = val[ORG_W-1:0];
      REG_ORIGIN_T: ot_sh = val[ORG_W-1:0];
      default: ;
    endcase
  endtask

  // value in the low bits, noise in the unused upper bits
  function automatic logic [CFG_DW-1:0] with_noise(logic [CFG_DW-1:0] v, int w);
    logic [CFG_DW-1:0] mask;
    mask = (32'd1 << w) - 1;
    return ($urandom & ~mask) | (v & mask);
  endfunction

  // drive one pixel position, queue its expected source coordinate on acceptance
  task automatic send_pixel(pixel_row_t p);
    coord_t c;
    in_ch.valid <= 1'b1;
    in_ch.out_col <= p.col;
    in_ch.out_row <= p.row;
    do @(posedge clk); while (!in_ch.ready);
    if (p.known) begin
      c.src_x = p.ex;
      c.src_y = p.ey;
    end else begin
      c.src_x = tan_project(int'(p.col) + int'(ol_sh), focal_sh, cx_sh);
      c.src_y = tan_project(int'(p.row) + int'(ot_sh), focal_sh, cy_sh);
    end
    coord_q.push_back(c);
    burst_left--;
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 300 : $urandom_range(1, 40);
    end
  endtask

  // wait until every expected coordinate has come back
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (coord_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // position near the angle range of the current focal length, or anywhere
  function automatic logic [POS_W-1:0] pick_pos(logic signed [ORG_W-1:0] org);
    int px, span, t;
    px = ((focal_sh < FOCAL_MIN) ? int'(FOCAL_MIN) : int'(focal_sh)) >> 8;
    span = px * 2 + 4;
    if ($urandom_range(0, 9) < 7) begin
      t = $urandom_range(0, 2 * span) - span - int'(org);
      if (t < 0) t = 0;
      if (t > 16383) t = 16383;
      return t[POS_W-1:0];
    end
    return POS_W'($urandom_range(0, 16383));
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_timer <= $urandom_range(20, 300);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= (stall_timer[3:0] < 4'd10);
    endcase
  end

  // result checker and watchdog
  always @(posedge clk) begin
    coord_t e;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (psel && penable && pwrite && pready)) idle_cycles = 0;
      else idle_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        if (coord_q.size() == 0) begin
          failures++;
          if (mismatches < 10) $display("unexpected item x=%0d y=%0d",
                                        out_ch.src_x_q5, out_ch.src_y_q5);
          mismatches++;
        end else begin
          e = coord_q.pop_front();
          if (e.src_x !== out_ch.src_x_q5 || e.src_y !== out_ch.src_y_q5) begin
            failures++;
            if (mismatches < 10)
              $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                       e.src_x, e.src_y, out_ch.src_x_q5, out_ch.src_y_q5);
            mismatches++;
          end
        end
      end
      if (idle_cycles > IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // directed table at reset settings, then random phases
  initial begin
    pixel_row_t directed[$];
    pixel_row_t p;
    burst_left = 8;
    focal_sh = FOCAL_RESET;
    cx_sh = '0;
    cy_sh = '0;
    ol_sh = '0;
    ot_sh = '0;
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.out_col <= '0;
    in_ch.out_row <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero position, known right-angle saturation cases, then tangent-region positions with a few past the right angle
    directed = '{
      '{14'd0,     14'd0,     1'b1, 19'sd0,  19'sd0},
      '{14'd16383, 14'd16383, 1'b1, OUT_MAX, OUT_MAX},
      '{14'd0,     14'd16383, 1'b1, 19'sd0,  OUT_MAX},
      '{14'd16383, 14'd0,     1'b1, OUT_MAX, 19'sd0},
      '{14'd8192,  14'd4096,  1'b1, OUT_MAX, OUT_MAX},
      '{14'd1,     14'd1,     1'b0, 19'sd0,  19'sd0},
      '{14'd1000,  14'd500,   1'b0, 19'sd0,  19'sd0},
      '{14'd1570,  14'd1571,  1'b0, 19'sd0,  19'sd0},
      '{14'd1569,  14'd1565,  1'b0, 19'sd0,  19'sd0},
      '{14'd785,   14'd1200,  1'b0, 19'sd0,  19'sd0},
      '{14'd10922, 14'd5461,  1'b0, 19'sd0,  19'sd0},
      '{14'd2,     14'd1500,  1'b0, 19'sd0,  19'sd0}
    };
    foreach (directed[i]) send_pixel(directed[i]);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        // focal below the minimum, centers and origins at their extremes
        0: begin
          reg_write(REG_FOCAL, with_noise(32'd0, FOCAL_W));
          reg_write(REG_CENTER_X, with_noise(32'h1FFFFF, FOCAL_W));
          reg_write(REG_CENTER_Y, with_noise(32'h1FFFFF, FOCAL_W));
          reg_write(REG_ORIGIN_L, with_noise(32'h4000, ORG_W));
          reg_write(REG_ORIGIN_T, with_noise(32'h3FFF, ORG_W));
        end
        1: begin
          reg_write(REG_FOCAL, with_noise(32'h1FFFFF, FOCAL_W));
          reg_write(REG_CENTER_X, with_noise(32'd0, FOCAL_W));
          reg_write(REG_CENTER_Y, with_noise(32'd0, FOCAL_W));
          reg_write(REG_ORIGIN_L, with_noise(32'h3FFF, ORG_W));
          reg_write(REG_ORIGIN_T, with_noise(32'h4001, ORG_W));
        end
        2: begin
          reg_write(REG_FOCAL, with_noise(32'd256, FOCAL_W));
          reg_write(REG_CENTER_X, with_noise($urandom, FOCAL_W));
          reg_write(REG_CENTER_Y, with_noise($urandom, FOCAL_W));
          reg_write(REG_ORIGIN_L, with_noise(32'd0, ORG_W));
          reg_write(REG_ORIGIN_T, with_noise(32'd0, ORG_W));
        end
        default: begin
          reg_write(REG_FOCAL, with_noise($urandom_range(256 * 16, 256 * 6000), FOCAL_W));
          reg_write(REG_CENTER_X, with_noise($urandom, FOCAL_W));
          reg_write(REG_CENTER_Y, with_noise($urandom, FOCAL_W));
          reg_write(REG_ORIGIN_L, with_noise($urandom_range(0, 32767), ORG_W));
          reg_write(REG_ORIGIN_T, with_noise($urandom_range(0, 32767), ORG_W));
        end
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        p.col = pick_pos(ol_sh);
        p.row = pick_pos(ot_sh);
        p.known = 1'b0;
        p.ex = '0;
        p.ey = '0;
        send_pixel(p);
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && coord_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/trc_pkg.sv
hdl/trc_ifs.sv
hdl/trc_div_cell.sv
hdl/trc_cordic_cell.sv
hdl/trc_axis.sv
hdl/tangential_remap_coordinate_generator.sv
tb/tb.sv
